/* rtl/itsr_pkg.sv */
// ----------------------------------------------------------------------------
// itsr_pkg
// Types and constants shared by the IMU timestamp resampler modules.
// ----------------------------------------------------------------------------
package itsr_pkg;

  localparam int AXES = 6;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POLL = 1'b1
  } req_type_t;

  typedef enum logic [0:0] {
    CFG_SPACING = 1'b0,
    CFG_GRAVITY = 1'b1
  } cfg_index_t;

  localparam logic [15:0] SPACING_RESET = 16'd5000;
  localparam logic [15:0] GRAVITY_RESET = 16'd4096;

  typedef struct packed {
    logic               req_type;
    logic        [63:0] timestamp;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_accel_x;
    logic signed [15:0] out_accel_y;
    logic signed [15:0] out_accel_z;
    logic signed [15:0] out_rate_x;
    logic signed [15:0] out_rate_y;
    logic signed [15:0] out_rate_z;
    logic        [1:0]  frame_index;
    logic               last_frame;
  } out_beat_t;

  typedef struct packed {
    logic               start;
    logic signed [47:0] dividend;
    logic signed [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [47:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/itsr_divider.sv */
// ----------------------------------------------------------------------------
// itsr_divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module itsr_divider (
  input  logic               clk,
  input  logic               rst,
  input  itsr_pkg::div_req_t req,
  output itsr_pkg::div_rsp_t rsp
);

  logic        [47:0] quo;
  logic        [32:0] rem;
  logic        [31:0] dvs;
  logic        [5:0]  cnt;
  logic               neg;
  logic               busy;
  logic               done;
  logic        [32:0] trial;

  assign trial = {rem[31:0], quo[47]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        quo  <= req.dividend[47] ? 48'(-req.dividend) : req.dividend;
        dvs  <= req.divisor[31] ? 32'(-req.divisor) : req.divisor;
        neg  <= req.dividend[47] ^ req.divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[47]};
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = neg ? 48'(-quo) : quo;

endmodule

/* rtl/imu_timestamp_resampler_unit.sv */
// ----------------------------------------------------------------------------
// imu_timestamp_resampler_unit
// Ring of timestamped six-axis samples with a linear interpolating poll.
// ----------------------------------------------------------------------------
// A push writes one ring entry. A poll produces three frames; each frame
// scans the fill count of stored timestamps newest first from one
// synchronous memory port, reads the two bracketing sample entries, then
// runs six serial divisions, each including product and handoff (none when
// the span is zero or no earlier sample exists), and presents the frame.
// With a full ring the time of a poll is set by the shared divider, plus any
// output stall; an empty ring gives its three rest frames without division.
// Input and configuration wait until the last frame is taken.
module imu_timestamp_resampler_unit #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  itsr_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itsr_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_END, S_RDA, S_RDB, S_LATCH, S_DIV, S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t state;

  logic [95:0] sample_mem [DEPTH];
  logic [63:0] time_mem   [DEPTH];

  logic [15:0]   spacing;
  logic [15:0]   gravity;
  logic [AW-1:0] wp;
  logic [CW-1:0] fill;
  logic [63:0]   now;
  logic [1:0]    frame;
  logic [63:0]   t_q;
  logic [CW-1:0] scan_i;
  logic          scan_vld;
  logic [AW-1:0] scan_ptr;
  logic [AW-1:0] scan_idx_d;
  logic [AW-1:0] rd_t_addr;
  logic [63:0]   rd_t;
  logic [AW-1:0] rd_s_addr;
  logic [95:0]   rd_s;
  logic          have_a, have_b;
  logic [AW-1:0] ai, bi;
  logic [63:0]   at, bt;
  logic [95:0]   sa, sb;
  logic [2:0]    axis;
  logic [15:0]   res [itsr_pkg::AXES];
  logic signed [31:0] span, num;
  logic signed [16:0] diff;
  logic signed [47:0] prod;
  logic               prod_go;
  itsr_pkg::div_req_t dreq;
  itsr_pkg::div_rsp_t drsp;

  itsr_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg_ready = (state == S_IDLE) && !out_valid && !in_valid;
  assign in_stall  = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    rd_t <= time_mem[rd_t_addr];
    rd_s <= sample_mem[rd_s_addr];
    if (in_valid && !in_stall && in_data.req_type == itsr_pkg::REQ_PUSH) begin
      time_mem[wp] <= in_data.timestamp;
      sample_mem[wp] <= {in_data.accel_x, in_data.accel_y, in_data.accel_z,
                         in_data.rate_x, in_data.rate_y, in_data.rate_z};
    end
  end

  assign rd_t_addr = scan_ptr;
  assign rd_s_addr = (state == S_RDA && have_a) ? ai : bi;

  logic signed [15:0] a_ax, b_ax;
  always_comb begin
    a_ax = 16'(sa >> (16 * (5 - axis)));
    b_ax = 16'(sb >> (16 * (5 - axis)));
  end

  assign dreq.start    = prod_go;
  assign dreq.dividend = prod;
  assign dreq.divisor  = span;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      spacing   <= itsr_pkg::SPACING_RESET;
      gravity   <= itsr_pkg::GRAVITY_RESET;
      wp        <= '0;
      fill      <= '0;
      prod_go   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (itsr_pkg::cfg_index_t'(cfg_index))
          itsr_pkg::CFG_SPACING: spacing <= cfg_data;
          itsr_pkg::CFG_GRAVITY: gravity <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (in_data.req_type == itsr_pkg::REQ_PUSH) begin
              wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
              if (fill != CW'(DEPTH)) fill <= fill + CW'(1);
            end else begin
              now   <= in_data.timestamp;
              frame <= 2'd0;
              t_q   <= in_data.timestamp - {47'd0, spacing, 1'b0};
              state <= S_SCAN;
              scan_i <= '0;
              scan_ptr <= (wp == '0) ? AW'(DEPTH - 1) : wp - AW'(1);
              scan_vld <= 1'b0;
              have_a <= 1'b0;
              have_b <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          scan_vld   <= scan_i < fill;
          scan_idx_d <= scan_ptr;
          scan_ptr   <= (scan_ptr == '0) ? AW'(DEPTH - 1) : scan_ptr - AW'(1);
          if (scan_vld) begin
            if (rd_t <= t_q) begin
              if (!have_a || rd_t > at) begin
                have_a <= 1'b1; ai <= scan_idx_d; at <= rd_t;
              end
            end else if (!have_b || rd_t < bt) begin
              have_b <= 1'b1; bi <= scan_idx_d; bt <= rd_t;
            end
          end
          if (scan_i >= fill) state <= S_SCAN_END;
          else scan_i <= scan_i + CW'(1);
        end
        S_SCAN_END: begin
          if (scan_vld) begin
            if (rd_t <= t_q) begin
              if (!have_a || rd_t > at) begin
                have_a <= 1'b1; ai <= scan_idx_d; at <= rd_t;
              end
            end else if (!have_b || rd_t < bt) begin
              have_b <= 1'b1; bi <= scan_idx_d; bt <= rd_t;
            end
          end
          scan_vld <= 1'b0;
          state <= (fill == '0) ? S_EMIT : S_RDA;
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          sa    <= rd_s;
          state <= S_LATCH;
        end
        S_LATCH: begin
          sb    <= rd_s;
          span  <= have_b ? 32'(bt - at) : 32'd0;
          num   <= 32'(t_q - at);
          axis  <= 3'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!have_a || span == 32'sd0) begin
            res[axis] <= a_ax;
            if (axis == 3'd5) state <= S_EMIT;
            else axis <= axis + 3'd1;
          end else begin
            diff <= 17'(b_ax) - 17'(a_ax);
            state <= S_DIV_WAIT;
            prod_go <= 1'b0;
          end
        end
        S_DIV_WAIT: begin
          if (!prod_go && !drsp.busy && !drsp.done && diff != 17'sh10000) begin
            prod    <= 48'(diff) * 48'(num);
            prod_go <= 1'b1;
            diff    <= 17'sh10000;
          end else begin
            prod_go <= 1'b0;
            if (drsp.done) begin
              res[axis] <= 16'(a_ax + 16'(drsp.quotient));
              if (axis == 3'd5) state <= S_EMIT;
              else begin
                axis  <= axis + 3'd1;
                state <= S_DIV;
              end
            end
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.frame_index <= frame;
            out_data.last_frame  <= frame == 2'd2;
            if (fill == '0) begin
              out_data.out_accel_x <= '0; out_data.out_accel_y <= '0;
              out_data.out_accel_z <= gravity; out_data.out_rate_x <= '0;
              out_data.out_rate_y <= '0; out_data.out_rate_z <= '0;
            end else begin
              out_data.out_accel_x <= res[0]; out_data.out_accel_y <= res[1];
              out_data.out_accel_z <= res[2]; out_data.out_rate_x <= res[3];
              out_data.out_rate_y <= res[4]; out_data.out_rate_z <= res[5];
            end
            if (frame == 2'd2) state <= S_IDLE;
            else begin
              frame <= frame + 2'd1;
              t_q <= now - ((frame == 2'd0) ? {48'd0, spacing} : 64'd0);
              scan_i <= '0; scan_vld <= 1'b0;
              scan_ptr <= (wp == '0) ? AW'(DEPTH - 1) : wp - AW'(1);
              have_a <= 1'b0; have_b <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_cap: assert property (@(posedge clk) disable iff (rst) fill <= CW'(DEPTH))
    else $error("fill count overflow");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_frame == (out_data.frame_index == 2'd2)))
    else $error("last_frame mismatch");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input accepted mid poll");
`endif

endmodule
